FILE: rtl/core/bda_pkg.sv
// package for the resource allocator: payload structs, status codes, reset totals
// no dependencies
package bda_pkg;
   localparam int CLASSES = 3;
   localparam int THREADS_DEFAULT = 8;
   localparam logic [7:0] TOTAL0_RESET = 8'd10;
   localparam logic [7:0] TOTAL1_RESET = 8'd8;
   localparam logic [7:0] TOTAL2_RESET = 8'd6;

   localparam logic [1:0] CSR_TOTAL0 = 2'd0;
   localparam logic [1:0] CSR_TOTAL1 = 2'd1;
   localparam logic [1:0] CSR_TOTAL2 = 2'd2;

   localparam logic OP_DECLARE = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   localparam logic [2:0] ST_GRANTED  = 3'd0;
   localparam logic [2:0] ST_OVERNEED = 3'd1;
   localparam logic [2:0] ST_NOAVAIL  = 3'd2;
   localparam logic [2:0] ST_UNSAFE   = 3'd3;
   localparam logic [2:0] ST_DECLARED = 3'd4;

   typedef struct packed {
      logic       operation;
      logic [2:0] thread;
      logic [7:0] amount_0;
      logic [7:0] amount_1;
      logic [7:0] amount_2;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       thread_done;
      logic [7:0] avail_0;
      logic [7:0] avail_1;
      logic [7:0] avail_2;
   } rsp_type;

   function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hff : s[7:0];
   endfunction
endpackage

FILE: rtl/core/bankers_deadlock_avoidance.sv
// banker's-algorithm allocator: three resource classes, per-thread need and held tables
// depends on bda_pkg and bda_ram
//
// usage: pulse start with a req_ beat while busy is low. a declare sets the thread's
// need, returns what it holds and clears its finished mark. a request is checked per
// class (over-need, then not available), granted tentatively, and a safety scan
// decides whether to keep it; a thread whose need reaches zero finishes and releases.
// each item gives exactly one rsp_ beat, shown for one cycle with rsp_valid; the
// receiver cannot stall, so nothing waits on it.
// need and held rows (24 bits each) live in two rams with registered reads. after
// reset a clearing pass writes a zero row for every thread; busy is high meanwhile.
// a declare or rejected request goes through read, evaluate and response states; a
// request that reaches the scan reads and checks each thread row in turn, restarting
// the pass after each pick; one item at a time. csr_ writes load a total into its
// available counter; the user must write while idle; the block does not enforce it.
module bankers_deadlock_avoidance
   import bda_pkg::*;
#(
   parameter int THREADS = THREADS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data
);
   localparam int TW = $clog2(THREADS);
   localparam int CW = $clog2(THREADS + 1);
   localparam int WW = 8 + CW;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_READ  = 8'b00000100,
      S_EVAL  = 8'b00001000,
      S_SCAN  = 8'b00010000,
      S_SWAIT = 8'b00100000,
      S_DONE  = 8'b01000000,
      S_RESP  = 8'b10000000
   } state_type;

   state_type         state_ff, state_in;
   logic [TW-1:0]     addr_ff, addr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [7:0]        avail_ff [CLASSES];
   logic [7:0]        avail_in [CLASSES];
   logic [THREADS-1:0] fin_ff, fin_in, pass_ff, pass_in;
   logic [WW-1:0]     work_ff [CLASSES];
   logic [WW-1:0]     work_in [CLASSES];
   req_type           req_ff;
   logic [2:0]        status_ff, status_in;
   logic              done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              wr_en;
   logic [TW-1:0]     wr_addr, rd_addr;
   logic [23:0]       need_wd, held_wd, need_rd, held_rd;

   bda_ram #(.WIDTH(24), .DEPTH(THREADS)) u_need (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(need_wd),
      .rd_addr(rd_addr), .rd_data(need_rd));
   bda_ram #(.WIDTH(24), .DEPTH(THREADS)) u_held (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(held_wd),
      .rd_addr(rd_addr), .rd_data(held_rd));

   logic [7:0] amt [CLASSES];
   logic [7:0] nd [CLASSES];
   logic [7:0] hd [CLASSES];
   logic       in_range;
   assign amt[0] = req_ff.amount_0;
   assign amt[1] = req_ff.amount_1;
   assign amt[2] = req_ff.amount_2;
   assign in_range = (32'(req_ff.thread) < THREADS);

   always_comb begin
      for (int c = 0; c < CLASSES; c++) begin
         nd[c] = need_rd[8*c +: 8];
         hd[c] = held_rd[8*c +: 8];
      end
   end

   logic [TW-1:0] req_t;
   assign req_t = TW'(req_ff.thread);

   always_comb begin
      logic fits, zero;
      logic [7:0] nn [CLASSES];
      logic [7:0] nh [CLASSES];
      state_in = state_ff;
      addr_in = addr_ff;
      cnt_in = cnt_ff;
      avail_in = avail_ff;
      fin_in = fin_ff;
      pass_in = pass_ff;
      work_in = work_ff;
      status_in = status_ff;
      done_in = done_ff;
      rsp_valid_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = req_t;
      need_wd = '0;
      held_wd = '0;
      rd_addr = req_t;
      fits = 1'b1;
      zero = 1'b1;
      for (int c = 0; c < CLASSES; c++) begin
         nn[c] = '0;
         nh[c] = '0;
      end
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = addr_ff;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == TW'(THREADS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            done_in = 1'b0;
            if (!in_range) begin
               status_in = ST_NOAVAIL;
               state_in = S_RESP;
            end else if (req_ff.operation == OP_DECLARE) begin
               for (int c = 0; c < CLASSES; c++) avail_in[c] = sat_add8(avail_ff[c], hd[c]);
               wr_en = 1'b1;
               need_wd = {req_ff.amount_2, req_ff.amount_1, req_ff.amount_0};
               held_wd = '0;
               fin_in[req_t] = 1'b0;
               status_in = ST_DECLARED;
               state_in = S_RESP;
            end else begin
               status_in = ST_GRANTED;
               for (int c = CLASSES - 1; c >= 0; c--) begin
                  if (amt[c] > nd[c]) status_in = ST_OVERNEED;
                  else if (amt[c] > avail_ff[c]) status_in = ST_NOAVAIL;
               end
               if (status_in != ST_GRANTED) begin
                  state_in = S_RESP;
               end else begin
                  for (int c = 0; c < CLASSES; c++) begin
                     avail_in[c] = avail_ff[c] - amt[c];
                     nn[c] = nd[c] - amt[c];
                     nh[c] = hd[c] + amt[c];
                     work_in[c] = WW'(avail_in[c]);
                  end
                  wr_en = 1'b1;
                  need_wd = {nn[2], nn[1], nn[0]};
                  held_wd = {nh[2], nh[1], nh[0]};
                  pass_in = '0;
                  addr_in = '0;
                  cnt_in = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_addr = addr_ff;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            // one thread per visit; restart pass after a pick
            for (int c = 0; c < CLASSES; c++)
               if (WW'(nd[c]) > work_ff[c]) fits = 1'b0;
            if (!pass_ff[addr_ff] && !fin_ff[addr_ff] && fits) begin
               for (int c = 0; c < CLASSES; c++) work_in[c] = work_ff[c] + WW'(hd[c]);
               pass_in[addr_ff] = 1'b1;
               addr_in = '0;
               cnt_in = cnt_ff + 1'b1;
               state_in = (cnt_ff == CW'(THREADS - 1)) ? S_DONE : S_SCAN;
            end else if (addr_ff == TW'(THREADS - 1)) begin
               state_in = S_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            // need_rd/held_rd still hold a reread of the requesting row
            if (((pass_ff | fin_ff) & ~pass_ff & ~fin_ff) != '0 || ((~pass_ff & ~fin_ff) != '0))
            begin
               for (int c = 0; c < CLASSES; c++) begin
                  avail_in[c] = avail_ff[c] + amt[c];
                  nn[c] = nd[c] + amt[c];
                  nh[c] = hd[c] - amt[c];
               end
               wr_en = 1'b1;
               need_wd = {nn[2], nn[1], nn[0]};
               held_wd = {nh[2], nh[1], nh[0]};
               status_in = ST_UNSAFE;
            end else begin
               for (int c = 0; c < CLASSES; c++) if (nd[c] != 8'd0) zero = 1'b0;
               if (zero) begin
                  for (int c = 0; c < CLASSES; c++) avail_in[c] = sat_add8(avail_ff[c], hd[c]);
                  wr_en = 1'b1;
                  need_wd = need_rd;
                  held_wd = '0;
                  fin_in[req_t] = 1'b1;
                  done_in = 1'b1;
               end
               status_in = ST_GRANTED;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_in == S_DONE) rd_addr = req_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         cnt_ff <= '0;
         fin_ff <= '0;
         pass_ff <= '0;
         rsp_valid_ff <= 1'b0;
         avail_ff[0] <= TOTAL0_RESET;
         avail_ff[1] <= TOTAL1_RESET;
         avail_ff[2] <= TOTAL2_RESET;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
         pass_ff <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         avail_ff <= avail_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TOTAL0: avail_ff[0] <= csr_wr_data;
               CSR_TOTAL1: avail_ff[1] <= csr_wr_data;
               CSR_TOTAL2: avail_ff[2] <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      status_ff <= status_in;
      done_ff <= done_in;
      if (state_ff == S_IDLE && start) req_ff <= req_data;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = '{status: status_ff, thread_done: done_ff,
                       avail_0: avail_ff[0], avail_1: avail_ff[1], avail_2: avail_ff[2]};

   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |-> state_ff == S_RESP) else $error("rsp without resp state");
   a_done_granted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.thread_done |-> rsp_data.status == ST_GRANTED)
      else $error("thread_done on non-grant");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == S_READ) else $error("start not taken");
endmodule

FILE: rtl/core/bda_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: tb/bankers_deadlock_avoidance_checker.sv
// checker for the resource allocator: watches req_/rsp_/csr_ beats, predicts each result
// depends on bda_pkg
`timescale 1ns / 1ps
module bankers_deadlock_avoidance_checker
   import bda_pkg::*;
#(
   parameter int THREADS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data,
   output int         fail_count,
   output int         pending
);
   logic [7:0] avail_units [CLASSES];
   logic [7:0] need_tab [THREADS][CLASSES];
   logic [7:0] held_tab [THREADS][CLASSES];
   logic       fin_mark [THREADS];
   rsp_type    expected_rsp [$];

   function automatic logic [7:0] sat8(logic [7:0] a, logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hff : s[7:0];
   endfunction

   function automatic bit state_is_safe();
      int  work [CLASSES];
      bit  passed [THREADS];
      bit  progress;
      bit  fits;
      for (int c = 0; c < CLASSES; c++) work[c] = avail_units[c];
      for (int t = 0; t < THREADS; t++) passed[t] = 0;
      progress = 1;
      while (progress) begin
         progress = 0;
         for (int t = 0; t < THREADS && !progress; t++) begin
            if (passed[t] || fin_mark[t]) continue;
            fits = 1;
            for (int c = 0; c < CLASSES; c++)
               if (need_tab[t][c] > work[c]) fits = 0;
            if (fits) begin
               for (int c = 0; c < CLASSES; c++) work[c] += held_tab[t][c];
               passed[t] = 1;
               progress = 1;
            end
         end
      end
      for (int t = 0; t < THREADS; t++)
         if (!passed[t] && !fin_mark[t]) return 0;
      return 1;
   endfunction

   function automatic rsp_type allocate(req_type r);
      rsp_type    o;
      logic [7:0] amt [CLASSES];
      int         t;
      bit         zero;
      amt[0] = r.amount_0; amt[1] = r.amount_1; amt[2] = r.amount_2;
      t = r.thread;
      o.status = ST_GRANTED;
      o.thread_done = 0;
      if (t >= THREADS) begin
         o.status = ST_NOAVAIL;
      end else if (r.operation == OP_DECLARE) begin
         for (int c = 0; c < CLASSES; c++) begin
            avail_units[c] = sat8(avail_units[c], held_tab[t][c]);
            held_tab[t][c] = 0;
            need_tab[t][c] = amt[c];
         end
         fin_mark[t] = 0;
         o.status = ST_DECLARED;
      end else begin
         for (int c = 0; c < CLASSES && o.status == ST_GRANTED; c++) begin
            if (amt[c] > need_tab[t][c]) o.status = ST_OVERNEED;
            else if (amt[c] > avail_units[c]) o.status = ST_NOAVAIL;
         end
         if (o.status == ST_GRANTED) begin
            for (int c = 0; c < CLASSES; c++) begin
               avail_units[c] -= amt[c];
               need_tab[t][c] -= amt[c];
               held_tab[t][c] += amt[c];
            end
            if (!state_is_safe()) begin
               for (int c = 0; c < CLASSES; c++) begin
                  avail_units[c] += amt[c];
                  need_tab[t][c] += amt[c];
                  held_tab[t][c] -= amt[c];
               end
               o.status = ST_UNSAFE;
            end else begin
               zero = 1;
               for (int c = 0; c < CLASSES; c++) if (need_tab[t][c] != 0) zero = 0;
               if (zero) begin
                  fin_mark[t] = 1;
                  for (int c = 0; c < CLASSES; c++) begin
                     avail_units[c] = sat8(avail_units[c], held_tab[t][c]);
                     held_tab[t][c] = 0;
                  end
                  o.thread_done = 1;
               end
            end
         end
      end
      o.avail_0 = avail_units[0];
      o.avail_1 = avail_units[1];
      o.avail_2 = avail_units[2];
      return o;
   endfunction

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         avail_units[0] = TOTAL0_RESET;
         avail_units[1] = TOTAL1_RESET;
         avail_units[2] = TOTAL2_RESET;
         for (int t = 0; t < THREADS; t++) begin
            fin_mark[t] = 0;
            for (int c = 0; c < CLASSES; c++) begin
               need_tab[t][c] = 0;
               held_tab[t][c] = 0;
            end
         end
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_data !== exp_r) begin
                  $display("%0t: mismatch, expected %h, actual %h", $time, exp_r, rsp_data);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en && csr_index < CLASSES) avail_units[csr_index] = csr_wr_data;
         if (start && !busy) expected_rsp.push_back(allocate(req_data));
      end
   end
endmodule

FILE: tb/bankers_deadlock_avoidance_tb.sv
// testbench top for the resource allocator: stimulus, idling phases, watchdog, verdict
// depends on bda_pkg, bankers_deadlock_avoidance and bankers_deadlock_avoidance_checker
`timescale 1ns / 1ps
module bankers_deadlock_avoidance_tb;
   import bda_pkg::*;

   localparam int LATENCY = 8 * 9 + 10;
   localparam int WATCHDOG = 20000;

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_wr_en = 0;
   logic [1:0] csr_index = CSR_TOTAL0;
   logic [7:0] csr_wr_data = 0;
   int         fail_count;
   int         pending;
   int         idle_pct;
   int         quiet_cycles;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   bankers_deadlock_avoidance u_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_wr_en, .csr_index, .csr_wr_data
   );

   bankers_deadlock_avoidance_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_wr_en, .csr_index, .csr_wr_data, .fail_count, .pending
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("[bankers_deadlock_avoidance] ERROR");
         $finish;
      end
   end

   task automatic send_beat(logic op, logic [2:0] thr, logic [7:0] a0, logic [7:0] a1,
                            logic [7:0] a2);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      req_data <= '{operation: op, thread: thr, amount_0: a0, amount_1: a1, amount_2: a2};
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_totals(logic [7:0] t0, logic [7:0] t1, logic [7:0] t2);
      logic [7:0] vals [3];
      vals[0] = t0; vals[1] = t1; vals[2] = t2;
      for (int i = 0; i < 3; i++) begin
         csr_wr_en <= 1;
         csr_index <= i[1:0];
         csr_wr_data <= vals[i];
         @(negedge clock);
      end
      csr_wr_en <= 0;
      @(negedge clock);
   endtask

   task automatic random_beat();
      logic [2:0] thr;
      logic [7:0] hi;
      thr = 3'($urandom_range(7));
      hi = ($urandom_range(9) == 0) ? 8'd255 : 8'd7;
      if ($urandom_range(9) == 0)
         send_beat(1'($urandom_range(1)), thr, 8'($urandom), 8'($urandom), 8'($urandom));
      else if ($urandom_range(3) == 0)
         send_beat(OP_DECLARE, thr, 8'($urandom_range(hi)), 8'($urandom_range(hi)),
                   8'($urandom_range(hi)));
      else
         send_beat(OP_REQUEST, thr, 8'($urandom_range(3)), 8'($urandom_range(3)),
                   8'($urandom_range(3)));
   endtask

   initial begin
      idle_pct = 0;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      while (busy) @(negedge clock);

      // directed: declares, over-need, not available, unsafe, finish, finished thread
      send_beat(OP_DECLARE, 3'd0, 8'd7, 8'd5, 8'd3);
      send_beat(OP_DECLARE, 3'd1, 8'd3, 8'd2, 8'd2);
      send_beat(OP_DECLARE, 3'd2, 8'd9, 8'd0, 8'd2);
      send_beat(OP_REQUEST, 3'd0, 8'd8, 8'd0, 8'd0);
      send_beat(OP_REQUEST, 3'd0, 8'd0, 8'd6, 8'd0);
      send_beat(OP_REQUEST, 3'd0, 8'd5, 8'd5, 8'd3);
      send_beat(OP_REQUEST, 3'd2, 8'd4, 8'd0, 8'd2);
      send_beat(OP_REQUEST, 3'd0, 8'd6, 8'd5, 8'd3);
      send_beat(OP_REQUEST, 3'd1, 8'd3, 8'd2, 8'd2);
      send_beat(OP_REQUEST, 3'd1, 8'd0, 8'd0, 8'd0);
      send_beat(OP_REQUEST, 3'd1, 8'd1, 8'd0, 8'd0);
      send_beat(OP_REQUEST, 3'd7, 8'd0, 8'd0, 8'd0);
      send_beat(OP_DECLARE, 3'd7, 8'd255, 8'd255, 8'd255);
      send_beat(OP_REQUEST, 3'd7, 8'd255, 8'd255, 8'd255);
      send_beat(OP_DECLARE, 3'd7, 8'd0, 8'd0, 8'd0);
      send_beat(OP_DECLARE, 3'd0, 8'd0, 8'd0, 8'd0);
      send_beat(OP_DECLARE, 3'd2, 8'd0, 8'd0, 8'd0);
      drain();

      write_totals(8'd255, 8'd255, 8'd255);
      send_beat(OP_DECLARE, 3'd4, 8'd200, 8'd200, 8'd200);
      send_beat(OP_REQUEST, 3'd4, 8'd200, 8'd100, 8'd1);
      drain();
      write_totals(8'd255, 8'd255, 8'd255);
      send_beat(OP_DECLARE, 3'd4, 8'd0, 8'd0, 8'd0);
      drain();
      write_totals(8'd0, 8'd0, 8'd0);
      send_beat(OP_REQUEST, 3'd5, 8'd0, 8'd0, 8'd0);
      send_beat(OP_REQUEST, 3'd6, 8'd1, 8'd0, 8'd0);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  write_totals(8'd10, 8'd8, 8'd6); end
            1: begin idle_pct = 74; write_totals(8'd12, 8'd12, 8'd12); end
            2: begin idle_pct = 15; write_totals(8'd5, 8'd9, 8'd3); end
            3: begin idle_pct = 0;  write_totals(8'd255, 8'd1, 8'd20); end
            default: begin idle_pct = 74; write_totals(8'd16, 8'd16, 8'd16); end
         endcase
         repeat (95) random_beat();
         drain();
      end

      if (fail_count == 0) $display("[bankers_deadlock_avoidance] OK");
      else $display("[bankers_deadlock_avoidance] ERROR");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/bda_pkg.sv
rtl/core/bda_ram.sv
rtl/core/bankers_deadlock_avoidance.sv
tb/bankers_deadlock_avoidance_checker.sv
tb/bankers_deadlock_avoidance_tb.sv
